// ===== sv/first_fit_heap_allocator_top_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define FFF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define FFF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/fff_pkg.sv =====
`default_nettype none
package fff_pkg;

   localparam int LEN_W    = 21;
   localparam int OFF_W    = 20;
   localparam int CNT_W    = 7;
   localparam int WIDE_W   = 23;
   localparam int TYPE_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [LEN_W-1:0] HEAP_LIMIT  = 21'd1048576;
   localparam int               MIN_TAIL    = 16;
   localparam int               ALIGN_BYTES = 16;

   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESIZE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_WALK,
      S_WCHK,
      S_POST_FIND,
      S_NX_CHK,
      S_POST_FIT,
      S_SPLIT,
      S_GRANT,
      S_FREE_RD,
      S_FREE_NX,
      S_FREE_MRG,
      S_POST_PRED,
      S_FINISH
   } fsm_type;

   typedef enum logic [1:0] {
      W_FIND,
      W_FIT,
      W_PRED
   } walk_type;

endpackage
`default_nettype wire

// ===== sv/fff_seg_ram.sv =====
`default_nettype none
module fff_seg_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 50
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== sv/first_fit_heap_allocator_top.sv =====
`default_nettype none
// Channel   Ports                         Direction  Moves
// request   req_valid/req_ready + fields  in         one item per request
// response  rsp_valid/rsp_ready + fields  out        one item per request
// config    csr_wr_en/csr_wr_data         in         heap size, no wait
//
// One request is in work at a time; the segment table walk reads one entry
// per cycle from the table memory. Allocate walks the list for a fit, release
// for the entry and then its predecessor, a moving resize also for a fit.
// After reset and after every configuration write an init pass rewrites slot 0
// when a header fits and clears all counters; no item is taken then.
// A waiting response stalls only the final step; the next item is taken
// while the response register still holds its item.
`include "first_fit_heap_allocator_top_defines.svh"
module first_fit_heap_allocator_top #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [fff_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [fff_pkg::LEN_W-1:0]    req_size,
   input  wire logic                         req_has_addr,
   input  wire logic [fff_pkg::OFF_W-1:0]    req_data_offset,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [fff_pkg::STATUS_W-1:0] rsp_status,
   output logic      [fff_pkg::OFF_W-1:0]    rsp_result_offset,
   output logic      [fff_pkg::OFF_W-1:0]    rsp_copy_source,
   output logic      [fff_pkg::LEN_W-1:0]    rsp_copy_length,
   output logic      [fff_pkg::LEN_W-1:0]    rsp_bytes_in_use,
   output logic      [fff_pkg::LEN_W-1:0]    rsp_peak_in_use,
   output logic      [fff_pkg::CNT_W-1:0]    rsp_live_grants,
   input  wire logic                         csr_wr_en,
   input  wire logic [fff_pkg::LEN_W-1:0]    csr_wr_data
);
   import fff_pkg::*;

   localparam int IW = $clog2(MAX_SEGMENTS + 1);
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam logic [IW-1:0]     NO_SEG   = IW'(MAX_SEGMENTS);
   localparam logic [WIDE_W-1:0] HDR_WIDE = WIDE_W'(HEADER_BYTES);
   localparam logic [WIDE_W-1:0] TAIL_MIN = WIDE_W'(HEADER_BYTES + MIN_TAIL);

   // one table entry: header position, data length, free mark, link
   typedef struct packed {
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] len;
      logic             free;
      logic [IW-1:0]    succ;
   } seg_type;

   localparam int DW = $bits(seg_type);

   fsm_type                state_ff, state_in;
   walk_type               wmode_ff, wmode_in;
   logic [TYPE_W-1:0]      kind_ff, kind_in;
   logic [LEN_W-1:0]       size_ff, size_in;
   logic [WIDE_W-1:0]      need_ff, need_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic                   found_ff, found_in;
   seg_type                ent_ff, ent_in;
   logic [IW-1:0]          s_ff, s_in;
   seg_type                s_ent_ff, s_ent_in;
   logic                   nx_valid_ff, nx_valid_in;
   logic                   moving_ff, moving_in;
   logic [STATUS_W-1:0]    pst_ff, pst_in;
   logic [OFF_W-1:0]       pres_ff, pres_in;
   logic [OFF_W-1:0]       psrc_ff, psrc_in;
   logic [LEN_W-1:0]       plen_ff, plen_in;
   logic [LEN_W-1:0]       used_ff, used_in;
   logic [LEN_W-1:0]       peak_ff, peak_in;
   logic [CNT_W-1:0]       grant_ff, grant_in;
   logic [LEN_W-1:0]       heap_ff, heap_in;
   logic [MAX_SEGMENTS-1:0] slot_use_ff, slot_use_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]       rsp_res_ff, rsp_res_in;
   logic [OFF_W-1:0]       rsp_src_ff, rsp_src_in;
   logic [LEN_W-1:0]       rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0]       rsp_used_ff, rsp_used_in;
   logic [LEN_W-1:0]       rsp_peak_ff, rsp_peak_in;
   logic [CNT_W-1:0]       rsp_grant_ff, rsp_grant_in;

   logic                   mem_we, mem_re;
   logic [AW-1:0]          mem_waddr, mem_raddr;
   seg_type                mem_wdata;
   logic [DW-1:0]          rd_bits;
   seg_type                rd_ent;

   logic [IW-1:0]          free_slot;
   logic                   free_ok;
   logic [WIDE_W-1:0]      size_up, need_c, comb_len, used_grow;
   logic                   hit, stop_miss;
   logic                   finish_wait;

   assign rd_ent = seg_type'(rd_bits);

   fff_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .AW    (AW),
      .DW    (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (DW'(mem_wdata)),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rd_bits)
   );

   // lowest unused slot for a split
   always_comb begin
      free_slot = NO_SEG;
      free_ok   = 1'b0;
      for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
         if (!slot_use_ff[i]) begin
            free_slot = IW'(i);
            free_ok   = 1'b1;
         end
      end
   end

   // size rounded up to the alignment
   assign size_up = WIDE_W'(req_size) + WIDE_W'(ALIGN_BYTES - 1);
   assign need_c  = WIDE_W'((size_up / ALIGN_BYTES) * ALIGN_BYTES);

   function automatic fsm_type post_of(walk_type m);
      fsm_type r;
      unique case (m)
         W_FIND:  r = S_POST_FIND;
         W_FIT:   r = S_POST_FIT;
         default: r = S_POST_PRED;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         slot_use_ff  <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         grant_ff     <= '0;
         heap_ff      <= HEAP_LIMIT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_use_ff  <= slot_use_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         grant_ff     <= grant_in;
         heap_ff      <= heap_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      wmode_ff      <= wmode_in;
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      need_ff       <= need_in;
      off_ff        <= off_in;
      cur_ff        <= cur_in;
      found_ff      <= found_in;
      ent_ff        <= ent_in;
      s_ff          <= s_in;
      s_ent_ff      <= s_ent_in;
      nx_valid_ff   <= nx_valid_in;
      moving_ff     <= moving_in;
      pst_ff        <= pst_in;
      pres_ff       <= pres_in;
      psrc_ff       <= psrc_in;
      plen_ff       <= plen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   always_comb begin
      state_in      = state_ff;
      wmode_in      = wmode_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      need_in       = need_ff;
      off_in        = off_ff;
      cur_in        = cur_ff;
      found_in      = found_ff;
      ent_in        = ent_ff;
      s_in          = s_ff;
      s_ent_in      = s_ent_ff;
      nx_valid_in   = nx_valid_ff;
      moving_in     = moving_ff;
      pst_in        = pst_ff;
      pres_in       = pres_ff;
      psrc_in       = psrc_ff;
      plen_in       = plen_ff;
      used_in       = used_ff;
      peak_in       = peak_ff;
      grant_in      = grant_ff;
      heap_in       = heap_ff;
      slot_use_in   = slot_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_grant_in  = rsp_grant_ff;
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff[AW-1:0];
      mem_wdata     = ent_ff;
      mem_re        = 1'b0;
      mem_raddr     = cur_ff[AW-1:0];
      hit           = 1'b0;
      stop_miss     = 1'b0;
      comb_len      = WIDE_W'(s_ent_ff.len) + HDR_WIDE + WIDE_W'(rd_ent.len);
      used_grow     = '0;

      unique case (state_ff)
         S_INIT: begin
            // rebuild the table as one free segment when a header fits
            slot_use_in = '0;
            used_in     = '0;
            peak_in     = '0;
            grant_in    = '0;
            if (WIDE_W'(heap_ff) >= HDR_WIDE) begin
               slot_use_in[0]  = 1'b1;
               mem_we          = 1'b1;
               mem_waddr       = '0;
               mem_wdata.start = '0;
               mem_wdata.len   = LEN_W'(WIDE_W'(heap_ff) - HDR_WIDE);
               mem_wdata.free  = 1'b1;
               mem_wdata.succ  = NO_SEG;
            end
            state_in = S_IDLE;
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in   = req_type;
               size_in   = req_size;
               need_in   = need_c;
               off_in    = req_data_offset;
               moving_in = 1'b0;
               pst_in    = ST_IGNORED;
               pres_in   = '0;
               psrc_in   = '0;
               plen_in   = '0;
               unique case (req_type)
                  REQ_ALLOC: begin
                     wmode_in = W_FIT;
                     state_in = S_WALK;
                  end
                  REQ_RELEASE: begin
                     wmode_in = W_FIND;
                     state_in = req_has_addr ? S_WALK : S_FINISH;
                  end
                  REQ_RESIZE: begin
                     // resize of null acts as allocate
                     wmode_in = req_has_addr ? W_FIND : W_FIT;
                     state_in = S_WALK;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end

         S_WALK: begin
            // start at the head of the list
            if (!slot_use_ff[0]) begin
               found_in = 1'b0;
               state_in = post_of(wmode_ff);
            end else begin
               cur_in    = '0;
               mem_re    = 1'b1;
               mem_raddr = '0;
               state_in  = S_WCHK;
            end
         end

         S_WCHK: begin
            unique case (wmode_ff)
               W_FIND: hit = (WIDE_W'(rd_ent.start) + HDR_WIDE) == WIDE_W'(off_ff);
               W_FIT:  hit = rd_ent.free && (WIDE_W'(rd_ent.len) >= need_ff);
               default: begin
                  stop_miss = (cur_ff == s_ff);
                  hit       = !stop_miss && (rd_ent.succ == s_ff);
               end
            endcase
            if (hit) begin
               found_in = 1'b1;
               ent_in   = rd_ent;
               state_in = post_of(wmode_ff);
            end else if (stop_miss || rd_ent.succ == NO_SEG) begin
               found_in = 1'b0;
               state_in = post_of(wmode_ff);
            end else begin
               // advance along the link, one entry per cycle
               cur_in    = rd_ent.succ;
               mem_re    = 1'b1;
               mem_raddr = rd_ent.succ[AW-1:0];
            end
         end

         S_POST_FIND: begin
            s_in     = cur_ff;
            s_ent_in = ent_ff;
            if (kind_ff == REQ_RELEASE) begin
               if (found_ff && !ent_ff.free) begin
                  pst_in   = ST_OK;
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (size_ff == '0) begin
               pst_in   = ST_RELEASED;
               state_in = (found_ff && !ent_ff.free) ? S_FREE_RD : S_FINISH;
            end else if (!found_ff || ent_ff.free) begin
               state_in = S_FINISH;
            end else if (need_ff <= WIDE_W'(ent_ff.len)) begin
               pst_in   = ST_OK;
               pres_in  = off_ff;
               state_in = S_FINISH;
            end else if (ent_ff.succ != NO_SEG) begin
               mem_re    = 1'b1;
               mem_raddr = ent_ff.succ[AW-1:0];
               state_in  = S_NX_CHK;
            end else begin
               moving_in = 1'b1;
               wmode_in  = W_FIT;
               state_in  = S_WALK;
            end
         end

         S_NX_CHK: begin
            // grow in place into a free successor, else start a moving fit walk
            if (rd_ent.free && comb_len >= need_ff) begin
               used_grow       = WIDE_W'(used_ff) + comb_len - WIDE_W'(s_ent_ff.len);
               used_in         = LEN_W'(used_grow);
               peak_in         = (LEN_W'(used_grow) > peak_ff) ? LEN_W'(used_grow) : peak_ff;
               mem_we          = 1'b1;
               mem_waddr       = s_ff[AW-1:0];
               mem_wdata       = s_ent_ff;
               mem_wdata.len   = LEN_W'(comb_len);
               mem_wdata.succ  = rd_ent.succ;
               slot_use_in[s_ent_ff.succ[AW-1:0]] = 1'b0;
               pst_in          = ST_OK;
               pres_in         = off_ff;
               state_in        = S_FINISH;
            end else begin
               moving_in = 1'b1;
               wmode_in  = W_FIT;
               state_in  = S_WALK;
            end
         end

         S_POST_FIT: begin
            if (!found_ff) begin
               pst_in   = ST_NO_MEM;
               state_in = S_FINISH;
            end else begin
               state_in = S_SPLIT;
            end
         end

         S_SPLIT: begin
            // cut off the tail when a header plus the minimum fits and a slot is free
            ent_in.free = 1'b0;
            if (WIDE_W'(ent_ff.len) >= need_ff + TAIL_MIN && free_ok) begin
               mem_we          = 1'b1;
               mem_waddr       = free_slot[AW-1:0];
               mem_wdata.start = LEN_W'(WIDE_W'(ent_ff.start) + HDR_WIDE + need_ff);
               mem_wdata.len   = LEN_W'(WIDE_W'(ent_ff.len) - need_ff - HDR_WIDE);
               mem_wdata.free  = 1'b1;
               mem_wdata.succ  = ent_ff.succ;
               slot_use_in[free_slot[AW-1:0]] = 1'b1;
               ent_in.len      = LEN_W'(need_ff);
               ent_in.succ     = free_slot;
            end
            state_in = S_GRANT;
         end

         S_GRANT: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff[AW-1:0];
            mem_wdata = ent_ff;
            used_grow = WIDE_W'(used_ff) + WIDE_W'(ent_ff.len);
            used_in   = LEN_W'(used_grow);
            peak_in   = (LEN_W'(used_grow) > peak_ff) ? LEN_W'(used_grow) : peak_ff;
            grant_in  = grant_ff + CNT_W'(1);
            pst_in    = ST_OK;
            pres_in   = OFF_W'(WIDE_W'(ent_ff.start) + HDR_WIDE);
            if (moving_ff) begin
               psrc_in  = off_ff;
               plen_in  = s_ent_ff.len;
               state_in = S_FREE_RD;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FREE_RD: begin
            mem_re    = 1'b1;
            mem_raddr = s_ff[AW-1:0];
            state_in  = S_FREE_NX;
         end

         S_FREE_NX: begin
            s_ent_in = rd_ent;
            used_in  = used_ff - rd_ent.len;
            grant_in = grant_ff - CNT_W'(1);
            if (rd_ent.succ != NO_SEG) begin
               mem_re      = 1'b1;
               mem_raddr   = rd_ent.succ[AW-1:0];
               nx_valid_in = 1'b1;
            end else begin
               nx_valid_in = 1'b0;
            end
            state_in = S_FREE_MRG;
         end

         S_FREE_MRG: begin
            // mark free, absorb a free successor
            mem_we         = 1'b1;
            mem_waddr      = s_ff[AW-1:0];
            mem_wdata      = s_ent_ff;
            mem_wdata.free = 1'b1;
            if (nx_valid_ff && rd_ent.free) begin
               mem_wdata.len  = LEN_W'(comb_len);
               mem_wdata.succ = rd_ent.succ;
               slot_use_in[s_ent_ff.succ[AW-1:0]] = 1'b0;
            end
            s_ent_in = mem_wdata;
            wmode_in = W_PRED;
            state_in = S_WALK;
         end

         S_POST_PRED: begin
            // fold into a free predecessor
            if (found_ff && ent_ff.free) begin
               mem_we         = 1'b1;
               mem_waddr      = cur_ff[AW-1:0];
               mem_wdata      = ent_ff;
               mem_wdata.len  = LEN_W'(WIDE_W'(ent_ff.len) + HDR_WIDE +
                                       WIDE_W'(s_ent_ff.len));
               mem_wdata.succ = s_ent_ff.succ;
               slot_use_in[s_ff[AW-1:0]] = 1'b0;
            end
            state_in = S_FINISH;
         end

         S_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_ff;
               rsp_res_in    = pres_ff;
               rsp_src_in    = psrc_ff;
               rsp_len_in    = plen_ff;
               rsp_used_in   = used_ff;
               rsp_peak_in   = peak_ff;
               rsp_grant_in  = grant_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_INIT;
      endcase

      // a heap size write re-initializes everything
      if (csr_wr_en) begin
         heap_in  = (csr_wr_data > HEAP_LIMIT) ? HEAP_LIMIT : csr_wr_data;
         state_in = S_INIT;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_offset = rsp_res_ff;
   assign rsp_copy_source   = rsp_src_ff;
   assign rsp_copy_length   = rsp_len_ff;
   assign rsp_bytes_in_use  = rsp_used_ff;
   assign rsp_peak_in_use   = rsp_peak_ff;
   assign rsp_live_grants   = rsp_grant_ff;

   assign finish_wait = (state_ff == S_FINISH) && rsp_valid_ff && !rsp_ready && !csr_wr_en;

   `FFF_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `FFF_ASSERT_IMP(a_head_in_use, |slot_use_ff, slot_use_ff[0])
   `FFF_ASSERT_NXT(a_finish_holds, finish_wait, state_ff == S_FINISH)

endmodule
`default_nettype wire

// ===== tb/sv/first_fit_heap_allocator_top_test.sv =====
`default_nettype none
module first_fit_heap_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fff_pkg::*;

   localparam int SEGS  = 64;
   localparam int HDR   = 32;
   localparam int ALIGN = 16;
   localparam int NONE  = SEGS;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [LEN_W-1:0]  CSR_MAX    = 21'h1FFFFF;

   // One expected response item.
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [OFF_W-1:0]    result_offset;
      logic [OFF_W-1:0]    copy_source;
      logic [LEN_W-1:0]    copy_length;
      logic [LEN_W-1:0]    bytes_in_use;
      logic [LEN_W-1:0]    peak_in_use;
      logic [CNT_W-1:0]    live_grants;
   } heap_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type = REQ_ALLOC;
   logic [LEN_W-1:0]    req_size = '0;
   logic                req_has_addr = 1'b0;
   logic [OFF_W-1:0]    req_data_offset = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [OFF_W-1:0]    rsp_result_offset;
   logic [OFF_W-1:0]    rsp_copy_source;
   logic [LEN_W-1:0]    rsp_copy_length;
   logic [LEN_W-1:0]    rsp_bytes_in_use;
   logic [LEN_W-1:0]    rsp_peak_in_use;
   logic [CNT_W-1:0]    rsp_live_grants;
   logic                csr_wr_en = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = '0;

   first_fit_heap_allocator_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_size          (req_size),
      .req_has_addr      (req_has_addr),
      .req_data_offset   (req_data_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_offset (rsp_result_offset),
      .rsp_copy_source   (rsp_copy_source),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_bytes_in_use  (rsp_bytes_in_use),
      .rsp_peak_in_use   (rsp_peak_in_use),
      .rsp_live_grants   (rsp_live_grants),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Shadow of the segment table, kept in step with every accepted item.
   int unsigned seg_base[SEGS];
   int unsigned seg_bytes[SEGS];
   int unsigned seg_link[SEGS];
   bit          seg_open[SEGS];
   bit          seg_taken[SEGS];
   int unsigned heap_size;
   int unsigned used_bytes;
   int unsigned peak_bytes;
   int unsigned grant_total;

   heap_answer_type pending_answers[$];
   int           mismatches = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         hold_ask = 1'b0;
   logic         hold_seen = 1'b0;
   int           hold_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Rebuild the table as one free segment spanning the region, when a header fits.
   function automatic void table_clear(int unsigned bytes);
      heap_size = bytes > HEAP_LIMIT ? HEAP_LIMIT : bytes;
      for (int i = 0; i < SEGS; i++) begin
         seg_base[i] = 0;
         seg_bytes[i] = 0;
         seg_link[i] = NONE;
         seg_open[i] = 1'b0;
         seg_taken[i] = 1'b0;
      end
      used_bytes = 0;
      peak_bytes = 0;
      grant_total = 0;
      if (heap_size >= HDR) begin
         seg_taken[0] = 1'b1;
         seg_bytes[0] = heap_size - HDR;
         seg_open[0] = 1'b1;
      end
   endfunction

   function automatic int unsigned list_head();
      return seg_taken[0] ? 0 : NONE;
   endfunction

   function automatic int unsigned seg_at(int unsigned off);
      int unsigned s;
      s = list_head();
      for (int n = 0; n < SEGS && s < NONE; n++) begin
         if (seg_base[s] + HDR == off) return s;
         s = seg_link[s];
      end
      return NONE;
   endfunction

   function automatic int unsigned round_to_grain(int unsigned size);
      return ((size + ALIGN - 1) / ALIGN) * ALIGN;
   endfunction

   function automatic void bump_peak();
      if (used_bytes > peak_bytes) peak_bytes = used_bytes;
   endfunction

   function automatic void unlink(int unsigned s);
      seg_taken[s] = 1'b0;
      seg_open[s] = 1'b0;
      seg_bytes[s] = 0;
      seg_base[s] = 0;
      seg_link[s] = NONE;
   endfunction

   // First fit; split off the tail when a header plus a minimum tail remains and a slot is spare.
   function automatic int unsigned carve(int unsigned size);
      int unsigned need, s, spare;
      int n;
      need = round_to_grain(size);
      s = list_head();
      for (n = 0; n < SEGS && s < NONE; n++) begin
         if (seg_open[s] && seg_bytes[s] >= need) break;
         s = seg_link[s];
      end
      if (n >= SEGS || s >= NONE) return NONE;
      if (seg_bytes[s] >= need + HDR + MIN_TAIL) begin
         spare = NONE;
         for (int i = SEGS - 1; i >= 0; i--)
            if (!seg_taken[i]) spare = i;
         if (spare < NONE) begin
            seg_taken[spare] = 1'b1;
            seg_base[spare] = seg_base[s] + HDR + need;
            seg_bytes[spare] = seg_bytes[s] - need - HDR;
            seg_open[spare] = 1'b1;
            seg_link[spare] = seg_link[s];
            seg_bytes[s] = need;
            seg_link[s] = spare;
         end
      end
      seg_open[s] = 1'b0;
      used_bytes += seg_bytes[s];
      bump_peak();
      grant_total++;
      return s;
   endfunction

   // Give a granted segment back and merge it with free neighbors.
   function automatic void give_back(int unsigned s);
      int unsigned nx, c;
      seg_open[s] = 1'b1;
      used_bytes -= seg_bytes[s];
      grant_total--;
      nx = seg_link[s];
      if (nx < NONE && seg_open[nx]) begin
         seg_bytes[s] += HDR + seg_bytes[nx];
         seg_link[s] = seg_link[nx];
         unlink(nx);
      end
      c = list_head();
      for (int n = 0; n < SEGS && c < NONE; n++) begin
         if (c == s) break;
         if (seg_link[c] == s) begin
            if (seg_open[c]) begin
               seg_bytes[c] += HDR + seg_bytes[s];
               seg_link[c] = seg_link[s];
               unlink(s);
            end
            break;
         end
         c = seg_link[c];
      end
   endfunction

   function automatic heap_answer_type heap_step(logic [TYPE_W-1:0] kind,
                                                 logic [LEN_W-1:0] size,
                                                 logic has, logic [OFF_W-1:0] off);
      heap_answer_type a;
      int unsigned s, g, nx, need, comb, old_len, st, res, src, len;
      st = ST_IGNORED;
      res = 0;
      src = 0;
      len = 0;
      if (kind == REQ_ALLOC || (kind == REQ_RESIZE && !has)) begin
         g = carve(size);
         if (g < NONE) begin
            st = ST_OK;
            res = seg_base[g] + HDR;
         end else begin
            st = ST_NO_MEM;
         end
      end else if (kind == REQ_RELEASE) begin
         s = has ? seg_at(off) : NONE;
         if (s < NONE && !seg_open[s]) begin
            give_back(s);
            st = ST_OK;
         end
      end else if (kind == REQ_RESIZE) begin
         s = seg_at(off);
         if (size == 0) begin
            if (s < NONE && !seg_open[s]) give_back(s);
            st = ST_RELEASED;
         end else if (s < NONE && !seg_open[s]) begin
            need = round_to_grain(size);
            nx = seg_link[s];
            comb = nx < NONE ? seg_bytes[s] + HDR + seg_bytes[nx] : 0;
            if (need <= seg_bytes[s]) begin
               st = ST_OK;
               res = off;
            end else if (nx < NONE && seg_open[nx] && comb >= need) begin
               used_bytes += comb - seg_bytes[s];
               bump_peak();
               seg_bytes[s] = comb;
               seg_link[s] = seg_link[nx];
               unlink(nx);
               st = ST_OK;
               res = off;
            end else begin
               old_len = seg_bytes[s];
               g = carve(size);
               if (g < NONE) begin
                  st = ST_OK;
                  res = seg_base[g] + HDR;
                  src = off;
                  len = old_len;
                  give_back(s);
               end else begin
                  st = ST_NO_MEM;
               end
            end
         end
      end
      a.status = st[STATUS_W-1:0];
      a.result_offset = res[OFF_W-1:0];
      a.copy_source = src[OFF_W-1:0];
      a.copy_length = len[LEN_W-1:0];
      a.bytes_in_use = used_bytes[LEN_W-1:0];
      a.peak_in_use = peak_bytes[LEN_W-1:0];
      a.live_grants = grant_total[CNT_W-1:0];
      return a;
   endfunction

   // Random granted data offset; found is 0 when nothing is granted.
   function automatic logic [OFF_W-1:0] any_grant(output bit found);
      int unsigned s, k, cnt;
      cnt = 0;
      s = list_head();
      for (int n = 0; n < SEGS && s < NONE; n++) begin
         if (!seg_open[s]) cnt++;
         s = seg_link[s];
      end
      found = cnt != 0;
      if (!found) return '0;
      k = $urandom_range(cnt - 1);
      s = list_head();
      for (int n = 0; n < SEGS && s < NONE; n++) begin
         if (!seg_open[s]) begin
            if (k == 0) return OFF_W'(seg_base[s] + HDR);
            k--;
         end
         s = seg_link[s];
      end
      return '0;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the item.
   // Valid stays high on return so back-to-back items need no dip.
   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [LEN_W-1:0] size,
                               input logic has, input logic [OFF_W-1:0] off,
                               output heap_answer_type answer);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_size <= size;
      req_has_addr <= has;
      req_data_offset <= off;
      do @(posedge clock); while (!req_ready);
      answer = heap_step(kind, size, has, off);
      pending_answers.push_back(answer);
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // Write the heap size only once the block has gone quiet.
   task automatic set_heap(input logic [LEN_W-1:0] bytes);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= bytes;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      table_clear(bytes);
   endtask

   task automatic test_basic_ops();
      heap_answer_type a, b, c;
      send_request(REQ_ALLOC, 21'd0, 1'b0, '0, a);
      send_request(REQ_ALLOC, 21'd1, 1'b1, 20'hFFFFF, a);
      send_request(REQ_ALLOC, 21'd100, 1'b0, '0, b);
      send_request(REQ_ALLOC, HEAP_LIMIT, 1'b0, '0, c);
      send_request(REQ_ALLOC, CSR_MAX, 1'b0, '0, c);
      send_request(REQ_RELEASE, '0, 1'b0, '0, c);
      send_request(REQ_RELEASE, '0, 1'b1, 20'hFFFFF, c);
      send_request(REQ_RESIZE, 21'd16, 1'b1, a.result_offset, c);
      send_request(REQ_RESIZE, 21'd64, 1'b1, a.result_offset, c);
      send_request(REQ_RELEASE, '0, 1'b1, b.result_offset, c);
      send_request(REQ_RESIZE, 21'd400, 1'b1, a.result_offset, c);
      send_request(REQ_RELEASE, '0, 1'b1, b.result_offset, c);
      send_request(REQ_ALLOC, 21'd48, 1'b0, '0, b);
      send_request(REQ_RESIZE, 21'd5000, 1'b1, a.result_offset, c);
      send_request(REQ_RESIZE, 21'd1000000, 1'b1, c.result_offset, a);
      send_request(REQ_RESIZE, 21'd2000000, 1'b1, b.result_offset, a);
      send_request(REQ_RESIZE, 21'd80, 1'b0, 20'h12345, a);
      send_request(REQ_RESIZE, 21'd0, 1'b1, a.result_offset, a);
      send_request(REQ_RESIZE, 21'd0, 1'b1, 20'h00010, a);
      send_request(REQ_RESIZE, 21'd64, 1'b1, 20'hABCDE, a);
      send_request(REQ_UNUSED, CSR_MAX, 1'b1, b.result_offset, a);
      send_request(REQ_RELEASE, '0, 1'b1, c.result_offset, a);
      stop_requests();
   endtask

   // Tiny regions: nothing fits, or only a zero-length segment exists.
   task automatic test_small_regions();
      heap_answer_type a;
      set_heap('0);
      send_request(REQ_ALLOC, '0, 1'b0, '0, a);
      stop_requests();
      set_heap(21'd20);
      send_request(REQ_ALLOC, 21'd1, 1'b0, '0, a);
      stop_requests();
      set_heap(21'd32);
      send_request(REQ_ALLOC, 21'd1, 1'b0, '0, a);
      send_request(REQ_ALLOC, '0, 1'b0, '0, a);
      send_request(REQ_ALLOC, '0, 1'b0, '0, a);
      send_request(REQ_RELEASE, '0, 1'b1, a.result_offset, a);
      stop_requests();
   endtask

   // Many tiny grants run the table out of slots; later splits are skipped.
   task automatic test_table_full();
      heap_answer_type a;
      set_heap(CSR_MAX);
      for (int i = 0; i < 68; i++) send_request(REQ_ALLOC, 21'd16, 1'b0, '0, a);
      stop_requests();
   endtask

   // Hold the receiver off while requests keep coming, so the input backs up.
   task automatic test_backpressure();
      heap_answer_type a;
      set_heap(21'd8192);
      hold_ask <= ~hold_ask;
      for (int i = 0; i < 12; i++)
         send_request(REQ_ALLOC, 21'($urandom_range(200)), 1'b0, '0, a);
      stop_requests();
   endtask

   task automatic test_random(input int count, input logic [LEN_W-1:0] bytes,
                              input int gap_pct, input int stall_pct);
      heap_answer_type a;
      logic [LEN_W-1:0] size;
      logic [OFF_W-1:0] off;
      bit found;
      int pick;
      set_heap(bytes);
      send_idle_pct = gap_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) < 70) size = 21'($urandom_range(256));
         else if ($urandom_range(99) < 85) size = 21'($urandom_range(8192));
         else size = 21'($urandom);
         off = any_grant(found);
         if (pick < 40 || (!found && pick < 82))
            send_request(REQ_ALLOC, size, 1'($urandom), 20'($urandom), a);
         else if (pick < 65)
            send_request(REQ_RELEASE, size, 1'b1, off, a);
         else if (pick < 82)
            send_request(REQ_RESIZE, size, 1'b1, off, a);
         else if (pick < 87)
            send_request(REQ_RESIZE, size, 1'b0, 20'($urandom), a);
         else if (pick < 91)
            send_request(REQ_RESIZE, '0, 1'($urandom), found ? off : 20'($urandom), a);
         else if (pick < 96)
            send_request(REQ_RELEASE, size, 1'($urandom), 20'($urandom), a);
         else
            send_request(REQ_UNUSED, 21'($urandom), 1'($urandom), 20'($urandom), a);
      end
      stop_requests();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Receiver: random stalls, plus a long hold whenever a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Check every accepted response against the oldest expectation.
   always @(posedge clock) begin
      heap_answer_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response item, status %0d", rsp_status);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status || rsp_result_offset !== e.result_offset ||
                rsp_copy_source !== e.copy_source || rsp_copy_length !== e.copy_length ||
                rsp_bytes_in_use !== e.bytes_in_use || rsp_peak_in_use !== e.peak_in_use ||
                rsp_live_grants !== e.live_grants) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st %0d off %h src %h len %0d used %0d peak %0d live %0d",
                           e.status, e.result_offset, e.copy_source, e.copy_length,
                           e.bytes_in_use, e.peak_in_use, e.live_grants);
                  $display("          got st %0d off %h src %h len %0d used %0d peak %0d live %0d",
                           rsp_status, rsp_result_offset, rsp_copy_source, rsp_copy_length,
                           rsp_bytes_in_use, rsp_peak_in_use, rsp_live_grants);
               end
            end
         end
      end
   end

   initial begin
      table_clear(HEAP_LIMIT);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_small_regions();
      test_table_full();
      test_backpressure();
      test_random(120, HEAP_LIMIT, 0, 0);
      test_random(110, 21'd4096, 64, 0);
      test_random(110, CSR_MAX, 0, 64);
      test_random(100, 21'd1500, 31, 31);
      drain();
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("first_fit_heap_allocator_top_test OK");
      end else begin
         $display("first_fit_heap_allocator_top_test NOT OK");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #40_000_000;
      $display("first_fit_heap_allocator_top_test NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/fff_pkg.sv
sv/fff_seg_ram.sv
sv/first_fit_heap_allocator_top.sv
tb/sv/first_fit_heap_allocator_top_test.sv
